// ===== design/scale2x_pixel_upscaler_core_assert.svh =====
// Assertion macros shared by the core.
`ifndef SCALE2X_PIXEL_UPSCALER_CORE_ASSERT_SVH
`define SCALE2X_PIXEL_UPSCALER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define S2X_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2x: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define S2X_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2x: next-cycle implication failed");

`endif

// ===== design/s2x_pkg.sv =====
package s2x_pkg;

    localparam int PIX_W          = 8;
    localparam int BX_W           = 10;
    localparam int BY_W           = 12;
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // One source pixel with its neighborhood and the blocks it releases
    typedef struct packed {
        pix_t            pix;
        pix_t            n_l;
        pix_t            n_c;
        pix_t            n_r;
        pix_t            o_c;
        pix_t            p_l1;
        pix_t            p_l2;
        logic [BX_W-1:0] bx;
        logic [BY_W-1:0] by;
        logic            do_top;
        logic            do_left;
        logic            do_end;
        logic            x0;
        logic            x1;
        logic            xl;
        logic            y0;
        logic            y1;
    } job_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } fifo_stat_t;

endpackage

// ===== design/s2x_front.sv =====
module s2x_front
    import s2x_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  fifo_stat_t            q_stat,
    output logic                  q_push,
    output job_t                  q_job
);

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [XW-1:0]           w_last;
    logic [YW-1:0]           h_last;

    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic          sel_reg;
    logic          x_last, y_last;
    logic [XW-1:0] rd_addr;
    logic          accept;

    pix_t bank0_mem [MAX_WIDTH];
    pix_t bank1_mem [MAX_WIDTH];
    pix_t rd0_reg, rd1_reg;

    logic          s1_valid_reg;
    pix_t          s1_pix_reg;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    logic          s1_sel_reg;
    logic          s1_fwd_reg;

    pix_t n_l_reg, n_c_reg, o_c_reg, p_l1_reg, p_l2_reg;
    pix_t rd_n, rd_o;
    logic s1_lr, s1_any, consume;
    job_t job;

    // Effective frame size: zero means one, oversize saturates
    always_comb
    begin
        if (width_reg == '0)
            w_last = '0;
        else if (int'(width_reg) > MAX_WIDTH)
            w_last = XW'(MAX_WIDTH - 1);
        else
            w_last = XW'(width_reg - 1'b1);
        if (height_reg == '0)
            h_last = '0;
        else if (int'(height_reg) > MAX_HEIGHT)
            h_last = YW'(MAX_HEIGHT - 1);
        else
            h_last = YW'(height_reg - 1'b1);
    end

    // Input handshake
    assign in_stall = s1_valid_reg && !q_stat.ready;
    assign accept   = in_valid && !in_stall;

    assign x_last  = (x_reg == w_last);
    assign y_last  = (y_reg == h_last);
    assign rd_addr = x_last ? '0 : XW'(x_reg + 1'b1);

    always_comb
    begin
        if (x_last)
        begin
            x_next = '0;
            y_next = y_last ? '0 : YW'(y_reg + 1'b1);
        end
        else
        begin
            x_next = XW'(x_reg + 1'b1);
            y_next = y_reg;
        end
    end

    // Config registers and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(1);
            height_reg <= HEIGHT_REG_W'(1);
            x_reg      <= '0;
            y_reg      <= '0;
            sel_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:
                begin
                    width_reg <= cfg_data[WIDTH_REG_W-1:0];
                    x_reg     <= '0;
                    y_reg     <= '0;
                end
                REG_HEIGHT:
                begin
                    height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                    x_reg      <= '0;
                    y_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            if (x_last)
                sel_reg <= !sel_reg;
        end
    end

    // Row stores: bank[sel] holds the previous row, the other one is refilled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (sel_reg)
                bank0_mem[x_reg] <= pixel;
            rd0_reg <= bank0_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!sel_reg)
                bank1_mem[x_reg] <= pixel;
            rd1_reg <= bank1_mem[rd_addr];
        end
    end

    // Stage one: pixel waiting for its read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (consume)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixel;
            s1_x_reg   <= x_reg;
            s1_y_reg   <= y_reg;
            s1_sel_reg <= x_last ? !sel_reg : sel_reg;
            s1_fwd_reg <= x_last && (x_reg == '0);
        end
    end

    // Previous row relative to the bank roles after this pixel
    assign rd_n = s1_sel_reg ? rd1_reg : rd0_reg;
    assign rd_o = s1_sel_reg ? rd0_reg : rd1_reg;

    // Classify the pixel
    assign s1_lr = (s1_y_reg == h_last);

    always_comb
    begin
        job.pix     = s1_pix_reg;
        job.n_l     = n_l_reg;
        job.n_c     = n_c_reg;
        job.n_r     = rd_n;
        job.o_c     = o_c_reg;
        job.p_l1    = p_l1_reg;
        job.p_l2    = p_l2_reg;
        job.bx      = BX_W'(s1_x_reg);
        job.by      = BY_W'(s1_y_reg);
        job.x0      = (s1_x_reg == '0);
        job.x1      = (s1_x_reg == XW'(1));
        job.xl      = (s1_x_reg == w_last);
        job.y0      = (s1_y_reg == '0);
        job.y1      = (s1_y_reg == YW'(1));
        job.do_top  = !job.y0;
        job.do_left = s1_lr && !job.x0;
        job.do_end  = s1_lr && job.xl;
    end

    assign s1_any  = job.do_top || job.do_left || job.do_end;
    assign consume = s1_valid_reg && q_stat.ready;
    assign q_push  = consume && s1_any;
    assign q_job   = job;

    // Slide the neighborhood window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_l_reg  <= '0;
            n_c_reg  <= '0;
            o_c_reg  <= '0;
            p_l1_reg <= '0;
            p_l2_reg <= '0;
        end
        else if (cfg_write)
        begin
            n_l_reg  <= '0;
            n_c_reg  <= '0;
            o_c_reg  <= '0;
            p_l1_reg <= '0;
            p_l2_reg <= '0;
        end
        else if (consume)
        begin
            n_l_reg  <= n_c_reg;
            n_c_reg  <= s1_fwd_reg ? s1_pix_reg : rd_n;
            o_c_reg  <= rd_o;
            p_l2_reg <= p_l1_reg;
            p_l1_reg <= s1_pix_reg;
        end
    end

endmodule

// ===== design/s2x_fifo.sv =====
module s2x_fifo
    import s2x_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output job_t       head_job,
    output fifo_stat_t stat
);

    job_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;

    assign stat.valid = (count_reg != '0);
    assign stat.ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign head_job   = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= FIFO_PTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= FIFO_PTR_W'(rd_ptr_reg + 1'b1);
            if (push && !pop)
                count_reg <= FIFO_CNT_W'(count_reg + 1'b1);
            else if (pop && !push)
                count_reg <= FIFO_CNT_W'(count_reg - 1'b1);
        end
    end

endmodule

// ===== design/s2x_back.sv =====
module s2x_back
    import s2x_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  fifo_stat_t      q_stat,
    input  job_t            head_job,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [PIX_W-1:0] top_left,
    output logic [PIX_W-1:0] top_right,
    output logic [PIX_W-1:0] bottom_left,
    output logic [PIX_W-1:0] bottom_right,
    output logic [BX_W-1:0] block_x,
    output logic [BY_W-1:0] block_y,
    output logic            last_of_run,
    output logic            frame_done
);

    logic [2:0] served_reg;
    logic [2:0] remaining;
    logic [2:0] pick;
    logic [2:0] left_after;
    logic       advance;
    logic       fire;

    pix_t            a, c, p, b, d;
    logic [BX_W-1:0] bx;
    logic [BY_W-1:0] by;
    logic            done;

    logic            out_valid_reg;
    pix_t            tl_reg, tr_reg, bl_reg, br_reg;
    logic [BX_W-1:0] bx_reg;
    logic [BY_W-1:0] by_reg;
    logic            last_reg, done_reg;

    // Blocks still owed for the head transaction: top, left, end
    assign remaining = {head_job.do_end, head_job.do_left, head_job.do_top} & ~served_reg;

    always_comb
    begin
        if (remaining[0])
            pick = 3'b001;
        else if (remaining[1])
            pick = 3'b010;
        else
            pick = 3'b100;
    end

    assign left_after = remaining & ~pick;
    assign advance    = !out_valid_reg || !out_stall;
    assign fire       = advance && q_stat.valid;
    assign q_pop      = fire && (left_after == '0);

    // Gather the neighborhood of the chosen block
    always_comb
    begin
        case (pick)
            3'b001:
            begin
                p    = head_job.n_c;
                a    = head_job.y1 ? p : head_job.o_c;
                c    = head_job.x0 ? p : head_job.n_l;
                b    = head_job.xl ? p : head_job.n_r;
                d    = head_job.pix;
                bx   = head_job.bx;
                by   = BY_W'(head_job.by - 1'b1);
                done = 1'b0;
            end
            3'b010:
            begin
                p    = head_job.p_l1;
                a    = head_job.y0 ? p : head_job.n_l;
                c    = head_job.x1 ? p : head_job.p_l2;
                b    = head_job.pix;
                d    = p;
                bx   = BX_W'(head_job.bx - 1'b1);
                by   = head_job.by;
                done = 1'b0;
            end
            default:
            begin
                p    = head_job.pix;
                a    = head_job.y0 ? p : head_job.n_c;
                c    = head_job.x0 ? p : head_job.p_l1;
                b    = p;
                d    = p;
                bx   = head_job.bx;
                by   = head_job.by;
                done = 1'b1;
            end
        endcase
    end

    // Track served blocks of the head transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            served_reg <= '0;
        else if (fire)
            served_reg <= (left_after == '0) ? '0 : (served_reg | pick);
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= q_stat.valid;
    end

    // Apply the corner rules into the output register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tl_reg   <= (c == a && c != d && a != b) ? a : p;
            tr_reg   <= (a == b && a != c && b != d) ? b : p;
            bl_reg   <= (d == c && d != b && c != a) ? c : p;
            br_reg   <= (b == d && b != a && d != c) ? d : p;
            bx_reg   <= bx;
            by_reg   <= by;
            last_reg <= (left_after == '0);
            done_reg <= done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign top_left     = tl_reg;
    assign top_right    = tr_reg;
    assign bottom_left  = bl_reg;
    assign bottom_right = br_reg;
    assign block_x      = bx_reg;
    assign block_y      = by_reg;
    assign last_of_run  = last_reg;
    assign frame_done   = done_reg;

endmodule

// ===== design/scale2x_pixel_upscaler_core.sv =====
// Channel   | Handshake           | Payload
// ----------+---------------------+----------------------------------------------
// input     | in_valid / in_stall | pixel
// output    | out_valid/out_stall | top_left top_right bottom_left bottom_right,
//           |                     | block_x block_y last_of_run frame_done
// config    | cfg_write           | cfg_index cfg_data
//
// One pixel enters per cycle unless in_stall is high; the output side emits one block
// per cycle while out_stall is low. A pixel releases at most one block in rows before
// the last, up to two in the last row and up to three for its final pixel. Its first
// block passes the read stage, the queue and the output register before it is valid.
// Each row store is one memory with at most one write and one read per pixel.
// Reset clears control and the window; the row stores need no clearing.
// A four-entry queue lets the input keep flowing while the output is stalled.
module scale2x_pixel_upscaler_core
    import s2x_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      top_left,
    output logic [PIX_W-1:0]      top_right,
    output logic [PIX_W-1:0]      bottom_left,
    output logic [PIX_W-1:0]      bottom_right,
    output logic [BX_W-1:0]       block_x,
    output logic [BY_W-1:0]       block_y,
    output logic                  last_of_run,
    output logic                  frame_done,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "scale2x_pixel_upscaler_core_assert.svh"

    fifo_stat_t q_stat;
    logic       q_push;
    logic       q_pop;
    job_t       q_job;
    job_t       head_job;

    // Accept, read row stores, classify
    s2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Decouple front and back
    s2x_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // Emit blocks
    s2x_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head_job     (head_job),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .top_left     (top_left),
        .top_right    (top_right),
        .bottom_left  (bottom_left),
        .bottom_right (bottom_right),
        .block_x      (block_x),
        .block_y      (block_y),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done)
    );

    `S2X_ASSERT_IMPLIES(a_push_has_room, q_push, q_stat.ready)
    `S2X_ASSERT_IMPLIES(a_pop_has_entry, q_pop, q_stat.valid)
    `S2X_ASSERT_IMPLIES(a_done_is_last, out_valid && frame_done, last_of_run)

endmodule

// ===== bench/scale2x_checker.sv =====
module scale2x_checker
    import s2x_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [PIX_W-1:0]      top_left,
    input  logic [PIX_W-1:0]      top_right,
    input  logic [PIX_W-1:0]      bottom_left,
    input  logic [PIX_W-1:0]      bottom_right,
    input  logic [BX_W-1:0]       block_x,
    input  logic [BY_W-1:0]       block_y,
    input  logic                  last_of_run,
    input  logic                  frame_done,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        pix_t            tl;
        pix_t            tr;
        pix_t            bl;
        pix_t            br;
        logic [BX_W-1:0] bx;
        logic [BY_W-1:0] by;
        logic            last;
        logic            done;
    } block_t;

    block_t                blocks_due[$];
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    pix_t                  cur_row[MAX_WIDTH_DEF];
    pix_t                  prev_row[MAX_WIDTH_DEF];
    int                    col;
    int                    row;

    // Apply the corner rules to one neighborhood and return the block
    function automatic block_t form_block(pix_t a, pix_t c, pix_t p, pix_t b, pix_t d,
                                          int bx, int by, logic done);
        block_t r;
        r.tl   = (c == a && c != d && a != b) ? a : p;
        r.tr   = (a == b && a != c && b != d) ? b : p;
        r.bl   = (d == c && d != b && c != a) ? c : p;
        r.br   = (b == d && b != a && d != c) ? d : p;
        r.bx   = bx[BX_W-1:0];
        r.by   = by[BY_W-1:0];
        r.last = 1'b0;
        r.done = done;
        return r;
    endfunction

    // Predict the blocks released by one accepted pixel
    task automatic predict_pixel(pix_t pix);
        int     w;
        int     h;
        int     x;
        int     y;
        bit     last_row;
        block_t run[$];
        block_t blk;
        pix_t   t;
        pix_t   p;
        pix_t   a;
        pix_t   c;
        pix_t   b;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF
                                                                   : height_reg;
        x = (col >= w) ? w - 1 : col;
        y = (row >= h) ? h - 1 : row;
        last_row = (row == h - 1);
        if (y > 0)
        begin
            p = prev_row[x];
            a = (y == 1) ? p : cur_row[x];
            c = (x == 0) ? p : prev_row[x - 1];
            b = (x + 1 >= w) ? p : prev_row[x + 1];
            run.push_back(form_block(a, c, p, b, pix, x, y - 1, 1'b0));
        end
        cur_row[x] = pix;
        if (last_row && x > 0)
        begin
            p = cur_row[x - 1];
            a = (y == 0) ? p : prev_row[x - 1];
            c = (x - 1 == 0) ? p : cur_row[x - 2];
            run.push_back(form_block(a, c, p, pix, p, x - 1, y, 1'b0));
        end
        if (last_row && x == w - 1)
        begin
            a = (y == 0) ? pix : prev_row[x];
            c = (x == 0) ? pix : cur_row[x - 1];
            run.push_back(form_block(a, c, pix, pix, pix, x, y, 1'b1));
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
        begin
            blk = run[i];
            blocks_due.push_back(blk);
        end
        // Swap rows at the end of a line and advance position
        if (x + 1 >= w)
        begin
            for (int i = 0; i < w; i++)
            begin
                t = prev_row[i];
                prev_row[i] = cur_row[i];
                cur_row[i] = t;
            end
            col = 0;
            row = last_row ? 0 : y + 1;
        end
        else
        begin
            col = x + 1;
            row = y;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        block_t got;
        block_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_REG_W'(1);
            height_reg = HEIGHT_REG_W'(1);
            col     = 0;
            row     = 0;
            errors  = 0;
            blocks_due.delete();
        end
        else
        begin
            // Compare an accepted output transaction with the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = '{top_left, top_right, bottom_left, bottom_right,
                        block_x, block_y, last_of_run, frame_done};
                if (blocks_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected block %p", got);
                end
                else
                begin
                    want = blocks_due.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("block mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_WIDTH)
                    width_reg = cfg_data[WIDTH_REG_W-1:0];
                else
                    height_reg = cfg_data[HEIGHT_REG_W-1:0];
                col = 0;
                row = 0;
            end
            else if (in_valid && !in_stall)
                predict_pixel(pixel);
        end
        pending = blocks_due.size();
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    import s2x_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      top_left;
    logic [PIX_W-1:0]      top_right;
    logic [PIX_W-1:0]      bottom_left;
    logic [PIX_W-1:0]      bottom_right;
    logic [BX_W-1:0]       block_x;
    logic [BY_W-1:0]       block_y;
    logic                  last_of_run;
    logic                  frame_done;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    int                    stall_left;
    bit                    stall_on;

    scale2x_pixel_upscaler_core uut (.*);
    scale2x_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Hold back the output in runs, mostly short with a few long ones
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (stall_on && ($urandom_range(0, 99) < 25))
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(1, 3);
        out_stall <= (stall_left > 0);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("** scale2x_pixel_upscaler_core: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one pixel transaction, idling first at random if gaps is set
    task automatic send_pixel(logic [PIX_W-1:0] v, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop the input and wait until every expected block has come out
    task automatic drain(int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_frame(int w, int h);
        drain(10);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_write <= 1'b0;
    endtask

    // Pixels from a small palette so that neighbor matches happen often, or any value when pal is zero
    function automatic logic [PIX_W-1:0] some_pixel(int pal);
        if (pal == 0) return PIX_W'($urandom_range(0, 255));
        return PIX_W'($urandom_range(0, pal));
    endfunction

    task automatic send_frame(int w, int h, int pal);
        for (int i = 0; i < w * h; i++)
            send_pixel(some_pixel(pal), 1'b1);
    endtask

    initial
    begin
        int sent;
        int w;
        int h;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pixel     = '0;
        cfg_write = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        stall_on  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset size 1x1, field extremes
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hA5, 1'b0);
        send_pixel(8'h5A, 1'b0);
        // Zero sizes act as one
        set_frame(0, 0);
        send_pixel(8'h11, 1'b0);
        // Single row, then a 3x3 with matching patterns
        set_frame(4, 1);
        send_frame(4, 1, 1);
        set_frame(3, 3);
        send_pixel(8'd1, 1'b0); send_pixel(8'd2, 1'b0); send_pixel(8'd1, 1'b0);
        send_pixel(8'd2, 1'b0); send_pixel(8'd3, 1'b0); send_pixel(8'd2, 1'b0);
        send_pixel(8'd1, 1'b0); send_pixel(8'd2, 1'b0); send_pixel(8'd1, 1'b0);
        // Height register write after a full frame, then a 3x2 frame
        drain(10);
        write_reg(REG_HEIGHT, 2);
        cfg_write <= 1'b0;
        send_frame(3, 2, 2);

        // Random frames with stalls on
        stall_on = 1'b1;
        sent = 0;
        while (sent < 340)
        begin
            w = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 9);
            h = $urandom_range(1, 6);
            set_frame(w, h);
            send_frame(w, h, ($urandom_range(0, 3) == 0) ? 0 : 3);
            sent += w * h;
            if ($urandom_range(0, 4) == 0)
                drain(0);
        end

        // Width and height saturation extremes, one short partial frame each
        set_frame(2047, 2);
        for (int i = 0; i < 12; i++) send_pixel(some_pixel(3), 1'b1);
        set_frame(1024, 8191);
        for (int i = 0; i < 12; i++) send_pixel(some_pixel(3), 1'b1);
        set_frame(1, 4096);
        for (int i = 0; i < 12; i++) send_pixel(some_pixel(0), 1'b1);

        drain(20);
        if (errors == 0)
            $display("** scale2x_pixel_upscaler_core: PASSED **");
        else
            $display("** scale2x_pixel_upscaler_core: FAILED **");
        $finish;
    end

endmodule

// ===== scale2x_pixel_upscaler_core.f =====
+incdir+design
design/s2x_pkg.sv
design/s2x_front.sv
design/s2x_fifo.sv
design/s2x_back.sv
design/scale2x_pixel_upscaler_core.sv
bench/scale2x_checker.sv
bench/tb.sv
